// ===== hw/rtl/brb_pkg.sv =====
// shared types and constants for the byte ring buffer
package brb_pkg;

  localparam int unsigned DEPTH_DEF    = 256;
  localparam int unsigned MAX_PUSH_DEF = 8;
  localparam int unsigned MAX_POP_DEF  = 64;

  localparam int SIZE_W    = 9;
  localparam int CNT_W     = 7;
  localparam int BYTE_W    = 8;
  localparam int FREE_W    = 8;
  localparam int NUM_BYTES = 8;

  localparam logic [SIZE_W-1:0] USED_SIZE_RST = 9'd256;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_BADCNT  = 2'd2
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [BYTE_W-1:0]      read_byte;
    logic                   last;
    logic [CNT_W-1:0]       popped_count;
    logic [FREE_W-1:0]      free_space;
  } res_t;

endpackage

// ===== hw/rtl/brb_ram.sv =====
// byte-wide storage, one write port and one registered read port
module brb_ram #(
  parameter int unsigned DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/brb_ctrl.sv =====
// sequencer with shared pointer wrap unit, one storage access per cycle
module brb_ctrl #(
  parameter int unsigned DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_PUSH = brb_pkg::MAX_PUSH_DEF,
  parameter int unsigned MAX_POP  = brb_pkg::MAX_POP_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [brb_pkg::SIZE_W-1:0]                 size_i,
  input  logic                                       cfg_clr_i,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       action_i,
  input  logic [brb_pkg::CNT_W-1:0]                  count_i,
  input  logic [brb_pkg::NUM_BYTES-1:0][brb_pkg::BYTE_W-1:0] bytes_i,
  output logic                                       res_valid_o,
  input  logic                                       res_ready_i,
  output brb_pkg::res_t                              res_o,
  output logic                                       ram_we_o,
  output logic [IW-1:0]                              ram_waddr_o,
  output logic [brb_pkg::BYTE_W-1:0]                 ram_wdata_o,
  output logic                                       ram_re_o,
  output logic [IW-1:0]                              ram_raddr_o,
  input  logic [brb_pkg::BYTE_W-1:0]                 ram_rdata_i
);
  import brb_pkg::*;

  localparam int AW = (IW > SIZE_W) ? IW : SIZE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_RESP = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, left_q, left_d;
  logic             rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0] npop_q, npop_d;
  logic [FREE_W-1:0] free_q, free_d;
  status_e          status_q, status_d;
  logic [NUM_BYTES-1:0][BYTE_W-1:0] bytes_q, bytes_d;

  logic [AW-1:0]    size_a, wr_a, rd_a, avail, room, cnt_a, ptr_sum;
  logic [IW-1:0]    ptr_sel, ptr_nxt;
  logic [CNT_W-1:0] n_cap, pop_n;
  logic             push_bad, accept, issue, ld;

  function automatic logic [FREE_W-1:0] sat_free(logic [AW-1:0] v);
    return (v > AW'(255)) ? '1 : v[FREE_W-1:0];
  endfunction

  assign size_a = AW'(size_i);
  assign wr_a   = AW'(wr_q);
  assign rd_a   = AW'(rd_q);
  assign avail  = (wr_a >= rd_a) ? (wr_a - rd_a) : (size_a - (rd_a - wr_a));
  assign room   = size_a - AW'(1) - avail;
  assign cnt_a  = AW'(count_i);

  assign push_bad = (count_i == '0) || (count_i > CNT_W'(MAX_PUSH));
  assign n_cap    = (count_i > CNT_W'(MAX_POP)) ? CNT_W'(MAX_POP) : count_i;
  assign pop_n    = (AW'(n_cap) > avail) ? CNT_W'(avail) : n_cap;

  // shared increment-and-wrap unit
  assign ptr_sel = (state_q == ST_PUSH) ? wr_q : rd_q;
  assign ptr_sum = AW'(ptr_sel) + AW'(1);
  assign ptr_nxt = (ptr_sum >= size_a) ? '0 : IW'(ptr_sum);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign issue      = (state_q == ST_POP) && (cnt_q != '0) && (!rd_pend_q || res_ready_i);
  assign ld         = (state_q == ST_POP) && rd_pend_q && res_ready_i;

  assign ram_we_o    = (state_q == ST_PUSH);
  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = bytes_q[0];
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_q;

  assign res_valid_o = (state_q == ST_RESP) || ((state_q == ST_POP) && rd_pend_q);

  always_comb begin
    res_o.popped_count = npop_q;
    res_o.free_space   = free_q;
    if (state_q == ST_POP) begin
      res_o.status    = STAT_OK;
      res_o.read_byte = ram_rdata_i;
      res_o.last      = (left_q == CNT_W'(1));
    end else begin
      res_o.status    = status_q;
      res_o.read_byte = '0;
      res_o.last      = 1'b1;
    end
  end

  always_comb begin
    state_d   = state_q;
    wr_d      = wr_q;
    rd_d      = rd_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    rd_pend_d = rd_pend_q;
    npop_d    = npop_q;
    free_d    = free_q;
    status_d  = status_q;
    bytes_d   = bytes_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_PUSH) begin
            npop_d = '0;
            cnt_d  = '0;
            if (push_bad) begin
              status_d = STAT_BADCNT;
              free_d   = sat_free(room);
              state_d  = ST_RESP;
            end else if (cnt_a > room) begin
              status_d = STAT_NOSPACE;
              free_d   = sat_free(room);
              state_d  = ST_RESP;
            end else begin
              status_d = STAT_OK;
              free_d   = sat_free(room - cnt_a);
              cnt_d    = count_i;
              bytes_d  = bytes_i;
              state_d  = ST_PUSH;
            end
          end else begin
            status_d = STAT_OK;
            npop_d   = pop_n;
            free_d   = sat_free(room + AW'(pop_n));
            cnt_d    = pop_n;
            left_d   = pop_n;
            state_d  = (pop_n == '0) ? ST_RESP : ST_POP;
          end
        end
      end
      ST_PUSH: begin
        wr_d  = ptr_nxt;
        cnt_d = cnt_q - CNT_W'(1);
        for (int i = 0; i < NUM_BYTES - 1; i++) begin
          bytes_d[i] = bytes_q[i+1];
        end
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_RESP;
        end
      end
      ST_POP: begin
        if (issue) begin
          rd_d      = ptr_nxt;
          cnt_d     = cnt_q - CNT_W'(1);
          rd_pend_d = 1'b1;
        end else if (ld) begin
          rd_pend_d = 1'b0;
        end
        if (ld) begin
          left_d = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // size change empties the buffer
    if (cfg_clr_i) begin
      wr_d = '0;
      rd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      left_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    npop_q   <= npop_d;
    free_q   <= free_d;
    status_q <= status_d;
    bytes_q  <= bytes_d;
  end

`ifndef SYNTHESIS
  a_pend_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> state_q == ST_POP)
    else $error("read pending outside pop");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (AW'(wr_q) < size_a) && (AW'(rd_q) < size_a))
    else $error("pointer beyond buffer size");

  a_push_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == ACT_PUSH) |=> state_q == ST_PUSH || state_q == ST_RESP)
    else $error("push went to wrong state");

  a_last_ends_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld && (left_q == CNT_W'(1)) |=> state_q == ST_IDLE && !rd_pend_q)
    else $error("pop did not end on last byte");
`endif

endmodule

// ===== hw/rtl/byte_ring_buffer.sv =====
// byte ring buffer top level: size register, sequencer, storage, output register
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o   | action, count, byte0..byte7
//   out     | output    | out_valid_o / out_stall_i | status, read_byte, last,
//           |           |                           | popped_count, free_space
//   cfg     | input     | cfg_we_i                  | cfg_wdata_i (used_size)
//
// push writes one byte per cycle to storage, then gives a single result
// pop of n bytes streams one byte per cycle through the registered read port
//   while out is not stalled; an empty pop or bad push gives only a result
// storage (one byte a cycle) sets the rate when out is free; in_stall_o is high until
//   the last result of a transaction has moved to the output register
// reset clears pointers and sets used_size to 256; storage is not cleared
// out_stall_i holds the output register and, behind it, the sequencer
module byte_ring_buffer #(
  parameter int unsigned DEPTH    = brb_pkg::DEPTH_DEF,
  parameter int unsigned MAX_PUSH = brb_pkg::MAX_PUSH_DEF,
  parameter int unsigned MAX_POP  = brb_pkg::MAX_POP_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brb_pkg::SIZE_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         action_i,
  input  logic [brb_pkg::CNT_W-1:0]    count_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte0_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte1_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte2_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte3_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte4_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte5_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte6_i,
  input  logic [brb_pkg::BYTE_W-1:0]   byte7_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [brb_pkg::BYTE_W-1:0]   read_byte_o,
  output logic                         last_o,
  output logic [brb_pkg::CNT_W-1:0]    popped_count_o,
  output logic [brb_pkg::FREE_W-1:0]   free_space_o
);
  import brb_pkg::*;

  localparam int IW = $clog2(DEPTH);

  // size register and its clamped effective value
  logic [SIZE_W-1:0] used_size_q;
  logic [SIZE_W-1:0] size_eff;

  // sequencer to output register
  logic res_valid, res_ready;
  res_t res;

  // output register
  logic out_valid_q, out_valid_d;
  res_t out_q;

  // storage port
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [NUM_BYTES-1:0][BYTE_W-1:0] bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_size_q <= USED_SIZE_RST;
    end else if (cfg_we_i) begin
      used_size_q <= cfg_wdata_i;
    end
  end

  // zero acts as one slot (no capacity), oversize acts as full depth
  always_comb begin
    if (used_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (32'(used_size_q) > DEPTH) begin
      size_eff = SIZE_W'(DEPTH);
    end else begin
      size_eff = used_size_q;
    end
  end

  assign bytes = {byte7_i, byte6_i, byte5_i, byte4_i, byte3_i, byte2_i, byte1_i, byte0_i};

  brb_ctrl #(
    .DEPTH   (DEPTH),
    .MAX_PUSH(MAX_PUSH),
    .MAX_POP (MAX_POP)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_eff),
    .cfg_clr_i  (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .count_i    (count_i),
    .bytes_i    (bytes),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  brb_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign read_byte_o    = out_q.read_byte;
  assign last_o         = out_q.last;
  assign popped_count_o = out_q.popped_count;
  assign free_space_o   = out_q.free_space;

endmodule
